/* rtl/ppr_pkg.sv */
// shared types and constants for the point rotation pipeline
// no dependencies; imported by every ppr_* module and the top level

package ppr_pkg;

   localparam int ANG_W        = 17;   // input angle width
   localparam int Z_W          = 32;   // angle accumulator, 2^-24 degree units
   localparam int X_W          = 34;   // cordic x and y, Q2.30 with headroom
   localparam int CS_W         = 20;   // cosine and sine after rounding, Q2.16 with headroom
   localparam int R_W          = 14;   // residual angle in centidegrees
   localparam int MAG_W        = 13;   // magnitude of the residual
   localparam int TABLE_LEN    = 24;
   localparam int ANG_LAT      = 3;    // register stages in ppr_angle

   localparam int FULL_TURN    = 36000;
   localparam int QUARTER_TURN = 9000;
   localparam int EIGHTH_TURN  = 4500;

   // z = r * 2^24 / 100 = r * 167772 + floor(4r / 25)
   localparam int Z_INT_MUL    = 167772;
   localparam int Z_FRAC_MUL   = 20972;
   localparam int Z_FRAC_SHIFT = 17;

   localparam int GAIN_Q30     = 652032874;
   localparam int TRIG_SHIFT   = 14;
   localparam int ROUND_HALF   = 8192;
   localparam int FRAC_BITS    = 16;
   localparam int FRAC_MASK    = 65535;

   localparam logic [1:0] QUAD_ZERO  = 2'd0;
   localparam logic [1:0] QUAD_ONE   = 2'd1;
   localparam logic [1:0] QUAD_TWO   = 2'd2;
   localparam logic [1:0] QUAD_THREE = 2'd3;

   // atan(2^-i) in 2^-24 degree units
   localparam logic signed [Z_W-1:0] ATAN_TAB [TABLE_LEN] = '{
      32'sd754974720, 32'sd445687602, 32'sd235489089, 32'sd119537938,
      32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
      32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
      32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
      32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
      32'sd917,       32'sd458,       32'sd229,       32'sd115
   };

   typedef struct packed {
      logic signed [X_W-1:0] x;
      logic signed [X_W-1:0] y;
      logic signed [Z_W-1:0] z;
      logic [1:0]            quad;
   } cordic_type;

endpackage

/* rtl/ppr_angle.sv */
// angle reduction: wrap to a full turn, split into quadrant and residual,
// scale the residual to 2^-24 degree units; three register stages; uses ppr_pkg

module ppr_angle
   import ppr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic signed [ANG_W-1:0] in_angle,
   output logic                    out_valid,
   output logic signed [Z_W-1:0]   out_z,
   output logic [1:0]              out_quad
);

   logic signed [ANG_W+1:0] a_ext;
   logic signed [ANG_W+1:0] wrap;
   logic [15:0]             red_in;
   logic [15:0]             red_ff;
   logic                    v1_ff;

   logic signed [R_W-1:0]   r_in;
   logic signed [R_W-1:0]   r_ff;
   logic [1:0]              q_in;
   logic [1:0]              q_ff;
   logic                    v2_ff;

   logic [MAG_W-1:0]        mag;
   logic [30:0]             z_int;
   logic [27:0]             z_frac;
   logic [30:0]             z_mag;
   logic signed [Z_W-1:0]   z_in;
   logic signed [Z_W-1:0]   z_ff;
   logic [1:0]              q3_ff;
   logic                    v3_ff;

   // stage 1: modulo a full turn
   always_comb begin
      a_ext = (ANG_W+2)'(in_angle);
      if (a_ext < -FULL_TURN) begin
         wrap = a_ext + (ANG_W+2)'(2 * FULL_TURN);
      end else if (a_ext < 0) begin
         wrap = a_ext + (ANG_W+2)'(FULL_TURN);
      end else if (a_ext >= FULL_TURN) begin
         wrap = a_ext - (ANG_W+2)'(FULL_TURN);
      end else begin
         wrap = a_ext;
      end
      red_in = wrap[15:0];
   end

   // stage 2: nearest quarter turn and residual
   always_comb begin
      if (red_ff <= 16'(EIGHTH_TURN)) begin
         q_in = QUAD_ZERO;
         r_in = R_W'($signed({1'b0, red_ff}));
      end else if (red_ff <= 16'(QUARTER_TURN + EIGHTH_TURN)) begin
         q_in = QUAD_ONE;
         r_in = R_W'($signed({1'b0, red_ff}) - QUARTER_TURN);
      end else if (red_ff <= 16'(2 * QUARTER_TURN + EIGHTH_TURN)) begin
         q_in = QUAD_TWO;
         r_in = R_W'($signed({1'b0, red_ff}) - 2 * QUARTER_TURN);
      end else if (red_ff <= 16'(3 * QUARTER_TURN + EIGHTH_TURN)) begin
         q_in = QUAD_THREE;
         r_in = R_W'($signed({1'b0, red_ff}) - 3 * QUARTER_TURN);
      end else begin
         q_in = QUAD_ZERO;
         r_in = R_W'($signed({1'b0, red_ff}) - FULL_TURN);
      end
   end

   // stage 3: z = r * 2^24 / 100, truncated toward zero
   always_comb begin
      mag    = r_ff[R_W-1] ? MAG_W'(-r_ff) : MAG_W'(r_ff);
      z_int  = 31'(mag) * 31'(Z_INT_MUL);
      z_frac = 28'(mag) * 28'(Z_FRAC_MUL);
      z_mag  = z_int + 31'(z_frac[27:Z_FRAC_SHIFT]);
      z_in   = r_ff[R_W-1] ? -$signed({1'b0, z_mag}) : $signed({1'b0, z_mag});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      red_ff <= red_in;
      r_ff   <= r_in;
      q_ff   <= q_in;
      z_ff   <= z_in;
      q3_ff  <= q_ff;
   end

   assign out_valid = v3_ff;
   assign out_z     = z_ff;
   assign out_quad  = q3_ff;

endmodule

/* rtl/ppr_cordic_step.sv */
// one registered rotation-mode cordic iteration
// uses ppr_pkg for the stage record and the arctangent table

module ppr_cordic_step
   import ppr_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  cordic_type in_data,
   output logic       out_valid,
   output cordic_type out_data
);

   logic signed [X_W-1:0] xs;
   logic signed [X_W-1:0] ys;
   cordic_type            data_in;
   cordic_type            data_ff;
   logic                  valid_ff;

   always_comb begin
      xs = in_data.x >>> STEP;
      ys = in_data.y >>> STEP;
      data_in.quad = in_data.quad;
      if (!in_data.z[Z_W-1]) begin
         data_in.x = in_data.x - ys;
         data_in.y = in_data.y + xs;
         data_in.z = in_data.z - ATAN_TAB[STEP];
      end else begin
         data_in.x = in_data.x + ys;
         data_in.y = in_data.y - xs;
         data_in.z = in_data.z + ATAN_TAB[STEP];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* rtl/ppr_combine.sv */
// rounds cosine and sine, applies the quarter turn, forms pivot + R * delta,
// truncates toward zero and saturates; four register stages; uses ppr_pkg

module ppr_combine
   import ppr_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic signed [X_W-1:0]        in_x,
   input  logic signed [X_W-1:0]        in_y,
   input  logic [1:0]                   in_quad,
   input  logic signed [COORD_BITS-1:0] in_px,
   input  logic signed [COORD_BITS-1:0] in_py,
   input  logic signed [COORD_BITS:0]   in_dx,
   input  logic signed [COORD_BITS:0]   in_dy,
   output logic                         out_valid,
   output logic signed [COORD_BITS-1:0] out_x,
   output logic signed [COORD_BITS-1:0] out_y,
   output logic                         out_clipped
);

   localparam int PW = COORD_BITS + 1 + CS_W;
   localparam int SW = PW + 2;
   localparam logic signed [SW-1:0] HI =
      {{(SW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [SW-1:0] LO = ~HI;

   // stage 1
   logic signed [X_W-1:0]        c_full;
   logic signed [X_W-1:0]        s_full;
   logic signed [CS_W-1:0]       c_rnd;
   logic signed [CS_W-1:0]       s_rnd;
   logic signed [CS_W-1:0]       cq_in;
   logic signed [CS_W-1:0]       sq_in;
   logic signed [CS_W-1:0]       cq_ff;
   logic signed [CS_W-1:0]       sq_ff;
   logic signed [COORD_BITS-1:0] px1_ff;
   logic signed [COORD_BITS-1:0] py1_ff;
   logic signed [COORD_BITS:0]   dx1_ff;
   logic signed [COORD_BITS:0]   dy1_ff;
   logic                         v1_ff;

   // stage 2
   logic signed [PW-1:0]         dxc_ff;
   logic signed [PW-1:0]         dys_ff;
   logic signed [PW-1:0]         dxs_ff;
   logic signed [PW-1:0]         dyc_ff;
   logic signed [COORD_BITS-1:0] px2_ff;
   logic signed [COORD_BITS-1:0] py2_ff;
   logic                         v2_ff;

   // stage 3
   logic signed [SW-1:0]         sum_x_in;
   logic signed [SW-1:0]         sum_y_in;
   logic signed [SW-1:0]         sum_x_ff;
   logic signed [SW-1:0]         sum_y_ff;
   logic                         v3_ff;

   // stage 4
   logic signed [SW-1:0]         bias_x;
   logic signed [SW-1:0]         bias_y;
   logic signed [SW-1:0]         qx;
   logic signed [SW-1:0]         qy;
   logic signed [COORD_BITS-1:0] rx_in;
   logic signed [COORD_BITS-1:0] ry_in;
   logic                         clip_x;
   logic                         clip_y;
   logic signed [COORD_BITS-1:0] rx_ff;
   logic signed [COORD_BITS-1:0] ry_ff;
   logic                         clip_ff;
   logic                         v4_ff;

   always_comb begin
      c_full = (in_x + X_W'(ROUND_HALF)) >>> TRIG_SHIFT;
      s_full = (in_y + X_W'(ROUND_HALF)) >>> TRIG_SHIFT;
      c_rnd  = c_full[CS_W-1:0];
      s_rnd  = s_full[CS_W-1:0];
      case (in_quad)
         QUAD_ZERO: begin
            cq_in = c_rnd;
            sq_in = s_rnd;
         end
         QUAD_ONE: begin
            cq_in = -s_rnd;
            sq_in = c_rnd;
         end
         QUAD_TWO: begin
            cq_in = -c_rnd;
            sq_in = -s_rnd;
         end
         default: begin
            cq_in = s_rnd;
            sq_in = -c_rnd;
         end
      endcase
   end

   always_comb begin
      sum_x_in = (SW'(px2_ff) <<< FRAC_BITS) + SW'(dxc_ff) - SW'(dys_ff);
      sum_y_in = (SW'(py2_ff) <<< FRAC_BITS) + SW'(dxs_ff) + SW'(dyc_ff);
   end

   // truncate toward zero, then clamp
   always_comb begin
      bias_x = sum_x_ff[SW-1] ? SW'(FRAC_MASK) : SW'(0);
      bias_y = sum_y_ff[SW-1] ? SW'(FRAC_MASK) : SW'(0);
      qx     = (sum_x_ff + bias_x) >>> FRAC_BITS;
      qy     = (sum_y_ff + bias_y) >>> FRAC_BITS;
      clip_x = 1'b1;
      clip_y = 1'b1;
      if (qx > HI) begin
         rx_in = HI[COORD_BITS-1:0];
      end else if (qx < LO) begin
         rx_in = LO[COORD_BITS-1:0];
      end else begin
         rx_in  = qx[COORD_BITS-1:0];
         clip_x = 1'b0;
      end
      if (qy > HI) begin
         ry_in = HI[COORD_BITS-1:0];
      end else if (qy < LO) begin
         ry_in = LO[COORD_BITS-1:0];
      end else begin
         ry_in  = qy[COORD_BITS-1:0];
         clip_y = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      cq_ff    <= cq_in;
      sq_ff    <= sq_in;
      px1_ff   <= in_px;
      py1_ff   <= in_py;
      dx1_ff   <= in_dx;
      dy1_ff   <= in_dy;
      dxc_ff   <= PW'(dx1_ff) * PW'(cq_ff);
      dys_ff   <= PW'(dy1_ff) * PW'(sq_ff);
      dxs_ff   <= PW'(dx1_ff) * PW'(sq_ff);
      dyc_ff   <= PW'(dy1_ff) * PW'(cq_ff);
      px2_ff   <= px1_ff;
      py2_ff   <= py1_ff;
      sum_x_ff <= sum_x_in;
      sum_y_ff <= sum_y_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      clip_ff  <= clip_x | clip_y;
   end

   assign out_valid   = v4_ff;
   assign out_x       = rx_ff;
   assign out_y       = ry_ff;
   assign out_clipped = clip_ff;

endmodule

/* rtl/point_rotate_about_pivot_top.sv */
// top level of the point rotation pipeline
// uses ppr_pkg, ppr_angle, ppr_cordic_step and ppr_combine
//
// Rotates a source point about a pivot by an angle in hundredths of a degree,
// counter-clockwise positive, with a gain-compensated cordic.
// Input channel: a transaction is taken at a rising edge with start high and
// busy low; req_pivot_x/y, req_src_x/y and req_angle_centideg are sampled
// there. Any angle pattern wraps modulo a full turn.
// Result channel: rsp_valid is high for one cycle with rsp_rot_x, rsp_rot_y
// and rsp_clipped; the result is taken at the edge ending that cycle.
// Throughput: one transaction per clock while busy is low; reset sets busy and
// the first clock edge without reset clears it for good.
// Pipeline: one input register, three angle stages, one register per cordic
// iteration and four output stages lie between the accepting edge and the
// edge that takes the result.
// Reset clears every valid bit, so transactions in flight are dropped.
// The receiver has no way to stall; results are never held back.

module point_rotate_about_pivot_top
   import ppr_pkg::*;
#(
   parameter int COORD_BITS   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_pivot_x,
   input  logic signed [COORD_BITS-1:0] req_pivot_y,
   input  logic signed [COORD_BITS-1:0] req_src_x,
   input  logic signed [COORD_BITS-1:0] req_src_y,
   input  logic signed [ANG_W-1:0]      req_angle_centideg,
   output logic                         rsp_valid,
   output logic signed [COORD_BITS-1:0] rsp_rot_x,
   output logic signed [COORD_BITS-1:0] rsp_rot_y,
   output logic                         rsp_clipped
);

   localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
   localparam int DLY   = ANG_LAT + STEPS + 1;

   logic                         busy_ff;
   logic                         in_valid_in;
   logic                         in_valid_ff;
   logic signed [ANG_W-1:0]      angle_ff;
   logic signed [COORD_BITS:0]   dx_in;
   logic signed [COORD_BITS:0]   dy_in;

   logic signed [COORD_BITS-1:0] px_ff [DLY];
   logic signed [COORD_BITS-1:0] py_ff [DLY];
   logic signed [COORD_BITS:0]   dx_ff [DLY];
   logic signed [COORD_BITS:0]   dy_ff [DLY];

   logic                         ang_valid;
   logic signed [Z_W-1:0]        ang_z;
   logic [1:0]                   ang_quad;

   logic                         stage_valid [STEPS+1];
   cordic_type                   stage_data  [STEPS+1];

   assign in_valid_in = start & ~busy_ff;
   assign dx_in = (COORD_BITS+1)'(req_src_x) - (COORD_BITS+1)'(req_pivot_x);
   assign dy_in = (COORD_BITS+1)'(req_src_y) - (COORD_BITS+1)'(req_pivot_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         in_valid_ff <= 1'b0;
      end else begin
         busy_ff     <= 1'b0;
         in_valid_ff <= in_valid_in;
      end
   end

   // coordinates ride alongside the angle path
   always_ff @(posedge clock) begin
      angle_ff <= req_angle_centideg;
      px_ff[0] <= req_pivot_x;
      py_ff[0] <= req_pivot_y;
      dx_ff[0] <= dx_in;
      dy_ff[0] <= dy_in;
      for (int k = 1; k < DLY; k++) begin
         px_ff[k] <= px_ff[k-1];
         py_ff[k] <= py_ff[k-1];
         dx_ff[k] <= dx_ff[k-1];
         dy_ff[k] <= dy_ff[k-1];
      end
   end

   ppr_angle u_angle (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_angle  (angle_ff),
      .out_valid (ang_valid),
      .out_z     (ang_z),
      .out_quad  (ang_quad)
   );

   assign stage_valid[0]     = ang_valid;
   assign stage_data[0].x    = X_W'(GAIN_Q30);
   assign stage_data[0].y    = '0;
   assign stage_data[0].z    = ang_z;
   assign stage_data[0].quad = ang_quad;

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      ppr_cordic_step #(
         .STEP (i)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_data   (stage_data[i]),
         .out_valid (stage_valid[i+1]),
         .out_data  (stage_data[i+1])
      );
   end

   ppr_combine #(
      .COORD_BITS (COORD_BITS)
   ) u_combine (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (stage_valid[STEPS]),
      .in_x        (stage_data[STEPS].x),
      .in_y        (stage_data[STEPS].y),
      .in_quad     (stage_data[STEPS].quad),
      .in_px       (px_ff[DLY-1]),
      .in_py       (py_ff[DLY-1]),
      .in_dx       (dx_ff[DLY-1]),
      .in_dy       (dy_ff[DLY-1]),
      .out_valid   (rsp_valid),
      .out_x       (rsp_rot_x),
      .out_y       (rsp_rot_y),
      .out_clipped (rsp_clipped)
   );

   assign busy = busy_ff;

endmodule
